// ===== design/ifmt_pkg.sv =====
// Package for the integer field formatter: widths, operation codes,
// ASCII constants and the digit-to-character lookup.
// Depends on nothing; used by every other file in design/.
`timescale 1ns / 1ps
`default_nettype none

package ifmt_pkg;

  // Fixed widths of the request and result fields.
  localparam int VALUE_W  = 64;
  localparam int OP_W     = 3;
  localparam int FWIDTH_W = 7;
  localparam int CHAR_W   = 8;

  localparam int MAX_FIELD_DEFAULT = 64;

  // Digit register: decimal needs 20 BCD digits for a 64-bit magnitude.
  localparam int DEC_DIGITS = 20;
  localparam int HEX_DIGITS = VALUE_W / 4;
  localparam int DIG_BITS   = DEC_DIGITS * 4;
  localparam int NDIG_W     = $clog2(DEC_DIGITS + 1);
  localparam int BITCNT_W   = $clog2(VALUE_W);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SDEC = 3'd0;
  localparam logic [OP_W-1:0] OP_UDEC = 3'd1;
  localparam logic [OP_W-1:0] OP_LHEX = 3'd2;
  localparam logic [OP_W-1:0] OP_UHEX = 3'd3;
  localparam logic [OP_W-1:0] OP_PTR  = 3'd4;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

  localparam logic [CHAR_W-1:0] HEX_LOWER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };
  localparam logic [CHAR_W-1:0] HEX_UPPER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // Control from the sequencer to the digit unit.
  typedef struct packed {
    logic start;
    logic dec;
    logic shift;
  } conv_ctrl_t;

  // Status from the digit unit.
  typedef struct packed {
    logic              done;
    logic [NDIG_W-1:0] ndig;
    logic [3:0]        top_digit;
  } conv_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    digit_char = upper ? HEX_UPPER[d] : HEX_LOWER[d];
  endfunction

endpackage

`default_nettype wire

// ===== design/ifmt_if.sv =====
// Handshake interfaces for the formatter: request channel and character channel.
// Depends on ifmt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ifmt_req_if;
  logic                           valid;
  logic                           ready;
  logic [ifmt_pkg::VALUE_W-1:0]   value;
  logic                           operand_size;
  logic [ifmt_pkg::OP_W-1:0]      operation;
  logic [ifmt_pkg::FWIDTH_W-1:0]  field_width;
  logic                           zero_pad;
  logic                           flush_left;

  modport source (output valid, value, operand_size, operation, field_width,
                  zero_pad, flush_left, input ready);
  modport sink (input valid, value, operand_size, operation, field_width,
                zero_pad, flush_left, output ready);
endinterface

interface ifmt_char_if;
  logic                          valid;
  logic                          ready;
  logic [ifmt_pkg::CHAR_W-1:0]   character;
  logic                          last;

  modport source (output valid, character, last, input ready);
  modport sink (input valid, character, last, output ready);
endinterface

`default_nettype wire

// ===== design/integer_field_formatter.sv =====
// Top level of the integer field formatter: request capture, field sequencer
// and registered character output. Depends on ifmt_pkg, ifmt_if and ifmt_conv.
//
//   Port      Dir   Contents
//   request   in    value, operand_size, operation, field_width, zero_pad, flush_left
//   result    out   character, last (one transfer per character of the field)
//
// One request is in flight at a time. Decimal requests pass through the bit-serial BCD
// converter; hex and pointer requests load directly. Leading zeros are then trimmed one
// digit at a time (at most 19 decimal, 15 hex dropped), after which one character leaves
// per cycle while the result does not stall. Reset is synchronous and empties the block;
// a new request is taken once the last character is registered.
`timescale 1ns / 1ps
`default_nettype none

module integer_field_formatter #(
  parameter int MAX_FIELD = ifmt_pkg::MAX_FIELD_DEFAULT
) (
  input wire logic   clk,
  input wire logic   rst,
  ifmt_req_if.sink   request,
  ifmt_char_if.source result
);

  localparam int CW = $clog2(MAX_FIELD + 1);

  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_EMIT} state_t;

  state_t                       state;
  logic [CW-1:0]                width_sat;
  logic                         zpad;
  logic                         left;
  logic                         neg;
  logic                         ptr;
  logic                         upper;
  logic [CW-1:0]                remain;
  logic [CW-1:0]                pre_cnt;
  logic [CW-1:0]                post_cnt;
  logic [1:0]                   pfx_cnt;
  logic [ifmt_pkg::NDIG_W-1:0]  dig_cnt;
  logic                         out_valid;
  logic [ifmt_pkg::CHAR_W-1:0]  out_char;
  logic                         out_last;

  logic                         accept;
  logic [ifmt_pkg::VALUE_W-1:0] v_ext;
  logic [ifmt_pkg::VALUE_W-1:0] mag;
  logic                         req_neg;
  logic                         req_dec;
  logic                         req_hexup;
  logic                         req_ptr;
  logic [1:0]                   pfx_len;
  logic [CW-1:0]                text_len;
  logic [CW-1:0]                pad;
  logic                         emit_go;
  logic [ifmt_pkg::CHAR_W-1:0]  next_char;
  logic                         take_digit;

  ifmt_pkg::conv_ctrl_t         conv_ctrl;
  ifmt_pkg::conv_stat_t         conv_stat;

  assign accept = request.valid && request.ready;

  // Operand extension and magnitude.
  always_comb begin
    if (request.operand_size) begin
      v_ext = request.value;
    end else begin
      v_ext = {{(ifmt_pkg::VALUE_W - 32){request.operation == ifmt_pkg::OP_SDEC
                                          && request.value[31]}},
               request.value[31:0]};
    end
    req_neg   = (request.operation == ifmt_pkg::OP_SDEC) && v_ext[ifmt_pkg::VALUE_W-1];
    mag       = req_neg ? (~v_ext + 1'b1) : v_ext;
    req_ptr   = (request.operation == ifmt_pkg::OP_PTR);
    req_hexup = (request.operation == ifmt_pkg::OP_UHEX);
    req_dec   = !(request.operation == ifmt_pkg::OP_LHEX ||
                  request.operation == ifmt_pkg::OP_UHEX ||
                  request.operation == ifmt_pkg::OP_PTR);
  end

  assign pfx_len  = neg ? 2'd1 : (ptr ? 2'd2 : 2'd0);
  assign text_len = CW'(conv_stat.ndig) + CW'(pfx_len);
  assign pad      = (width_sat > text_len) ? width_sat - text_len : '0;

  assign emit_go = (state == S_EMIT) && (!out_valid || result.ready);

  always_comb begin
    take_digit = 1'b0;
    priority if (pre_cnt != '0) begin
      next_char = zpad ? ifmt_pkg::CH_ZERO : ifmt_pkg::CH_SPACE;
    end else if (pfx_cnt != 2'd0) begin
      next_char = neg ? ifmt_pkg::CH_MINUS :
                  (pfx_cnt == 2'd2 ? ifmt_pkg::CH_ZERO : ifmt_pkg::CH_X);
    end else if (dig_cnt != '0) begin
      next_char  = ifmt_pkg::digit_char(conv_stat.top_digit, upper);
      take_digit = 1'b1;
    end else begin
      next_char = ifmt_pkg::CH_SPACE;
    end
  end

  assign conv_ctrl.start = accept;
  assign conv_ctrl.dec   = req_dec;
  assign conv_ctrl.shift = emit_go && take_digit;

  ifmt_conv u_conv (
    .clk  (clk),
    .rst  (rst),
    .ctrl (conv_ctrl),
    .mag  (mag),
    .stat (conv_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      out_char  <= '0;
      out_last  <= 1'b0;
      width_sat <= '0;
      zpad      <= 1'b0;
      left      <= 1'b0;
      neg       <= 1'b0;
      ptr       <= 1'b0;
      upper     <= 1'b0;
      remain    <= '0;
      pre_cnt   <= '0;
      post_cnt  <= '0;
      pfx_cnt   <= '0;
      dig_cnt   <= '0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
        out_char  <= next_char;
        out_last  <= (remain == CW'(1));
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            width_sat <= (request.field_width > ifmt_pkg::FWIDTH_W'(MAX_FIELD)) ?
                         CW'(MAX_FIELD) : request.field_width[CW-1:0];
            zpad      <= request.zero_pad && !request.flush_left;
            left      <= request.flush_left;
            neg       <= req_neg;
            ptr       <= req_ptr;
            upper     <= req_hexup;
            state     <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (conv_stat.done) begin
            remain   <= text_len + pad;
            pre_cnt  <= left ? '0 : pad;
            post_cnt <= left ? pad : '0;
            pfx_cnt  <= pfx_len;
            dig_cnt  <= conv_stat.ndig;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            remain <= remain - 1'b1;
            priority if (pre_cnt != '0) begin
              pre_cnt <= pre_cnt - 1'b1;
            end else if (pfx_cnt != 2'd0) begin
              pfx_cnt <= pfx_cnt - 1'b1;
            end else if (dig_cnt != '0) begin
              dig_cnt <= dig_cnt - 1'b1;
            end else begin
              post_cnt <= post_cnt - 1'b1;
            end
            if (remain == CW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign request.ready    = (state == S_IDLE);
  assign result.valid     = out_valid;
  assign result.character = out_char;
  assign result.last      = out_last;

  // The field never runs dry while characters are still being sequenced.
  a_remain_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (remain != '0))
    else $error("emit state with no characters left");

  // The final character of a field returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_go && remain == CW'(1)) |=> (state == S_IDLE && out_last))
    else $error("last character did not close the field");

  // Digits are only taken from a finished conversion.
  a_shift_when_done: assert property (@(posedge clk) disable iff (rst)
    conv_ctrl.shift |-> conv_stat.done)
    else $error("digit shift before conversion finished");

  // A request transfer closes the input until the field is out.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !request.ready)
    else $error("second request taken while one is in flight");

endmodule

`default_nettype wire

// ===== design/ifmt_conv.sv =====
// Digit unit: bit-serial binary to BCD conversion (shift and add-3), hex load,
// and leading-zero trimming; then hands out digits one nibble per shift.
// Depends on ifmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ifmt_conv (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ifmt_pkg::conv_ctrl_t         ctrl,
  input  wire logic [ifmt_pkg::VALUE_W-1:0] mag,
  output ifmt_pkg::conv_stat_t              stat
);

  typedef enum logic [1:0] {C_IDLE, C_CONV, C_TRIM, C_DONE} cstate_t;

  cstate_t                            state;
  logic [ifmt_pkg::DIG_BITS-1:0]      bcd;
  logic [ifmt_pkg::DIG_BITS-1:0]      bcd_adj;
  logic [ifmt_pkg::VALUE_W-1:0]       sr;
  logic [ifmt_pkg::BITCNT_W-1:0]      bit_cnt;
  logic [ifmt_pkg::NDIG_W-1:0]        ndig;

  // Digits of five or more get 3 added before the doubling shift.
  always_comb begin
    for (int i = 0; i < ifmt_pkg::DEC_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      bcd     <= '0;
      sr      <= '0;
      bit_cnt <= '0;
      ndig    <= '0;
    end else if (ctrl.start) begin
      bit_cnt <= '0;
      if (ctrl.dec) begin
        bcd   <= '0;
        sr    <= mag;
        state <= C_CONV;
      end else begin
        bcd   <= {mag, {(ifmt_pkg::DIG_BITS - ifmt_pkg::VALUE_W){1'b0}}};
        ndig  <= ifmt_pkg::NDIG_W'(ifmt_pkg::HEX_DIGITS);
        state <= C_TRIM;
      end
    end else begin
      unique case (state)
        C_IDLE: ;
        C_CONV: begin
          bcd     <= {bcd_adj[ifmt_pkg::DIG_BITS-2:0], sr[ifmt_pkg::VALUE_W-1]};
          sr      <= {sr[ifmt_pkg::VALUE_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == ifmt_pkg::BITCNT_W'(ifmt_pkg::VALUE_W - 1)) begin
            ndig  <= ifmt_pkg::NDIG_W'(ifmt_pkg::DEC_DIGITS);
            state <= C_TRIM;
          end
        end
        C_TRIM: begin
          // Drop leading zero digits, but always keep one.
          if (bcd[ifmt_pkg::DIG_BITS-1 -: 4] == 4'd0 && ndig > ifmt_pkg::NDIG_W'(1)) begin
            bcd  <= {bcd[ifmt_pkg::DIG_BITS-5:0], 4'd0};
            ndig <= ndig - 1'b1;
          end else begin
            state <= C_DONE;
          end
        end
        C_DONE: begin
          if (ctrl.shift) begin
            bcd <= {bcd[ifmt_pkg::DIG_BITS-5:0], 4'd0};
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign stat.done      = (state == C_DONE);
  assign stat.ndig      = ndig;
  assign stat.top_digit = bcd[ifmt_pkg::DIG_BITS-1 -: 4];

endmodule

`default_nettype wire
